// ----- rtl/core/lnd_pkg.sv -----
// Shared types and constants for the line node detector.
package lnd_pkg;

  // Fixed field widths of the ports
  localparam int FIELD_LEVEL_W = 12;
  localparam int STEP_W        = 16;
  localparam int MASK_W        = 4;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 16;

  localparam int LEVEL_BITS_DEF = 12;

  // Register reset values
  localparam int WHITE_LEVEL_RST     = 1000;
  localparam int BLACK_LEVEL_RST     = 300;
  localparam int CROSSING_LEVEL_RST  = 500;
  localparam int CENTER_DISTANCE_RST = 200;

  // Direction mask bit positions
  localparam int DIR_UP_BIT    = 0;
  localparam int DIR_DOWN_BIT  = 1;
  localparam int DIR_LEFT_BIT  = 2;
  localparam int DIR_RIGHT_BIT = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WHITE_LEVEL     = 2'd0,
    CFG_BLACK_LEVEL     = 2'd1,
    CFG_CROSSING_LEVEL  = 2'd2,
    CFG_CENTER_DISTANCE = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic                     abort;
    logic                     moving_forward;
    logic [FIELD_LEVEL_W-1:0] left_level;
    logic [FIELD_LEVEL_W-1:0] middle_level;
    logic [FIELD_LEVEL_W-1:0] right_level;
    logic [STEP_W-1:0]        steps_left;
    logic [STEP_W-1:0]        steps_right;
  } sample_t;

  typedef struct packed {
    logic              acted;
    logic              start_motion;
    logic              node_found;
    logic [MASK_W-1:0] direction_mask;
  } result_t;

endpackage

// ----- rtl/core/line_node_detector.sv -----
// Top level: input register, configuration registers and result register.
// The input register holds a transaction, and the result register holds its result.
// Throughput: one transaction per cycle while out_stall does not hold the result register;
// the single decision stage with its 16 x LW product and compare sets the cycle.
// Reset (rst_n low, synchronous): pipeline empty, detection idle, sums and
// counter zero, thresholds back to their default values.
module line_node_detector import lnd_pkg::*; #(
  parameter int LEVEL_BITS = LEVEL_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_abort,
  input  logic                     in_moving_forward,
  input  logic [FIELD_LEVEL_W-1:0] in_left_level,
  input  logic [FIELD_LEVEL_W-1:0] in_middle_level,
  input  logic [FIELD_LEVEL_W-1:0] in_right_level,
  input  logic [STEP_W-1:0]        in_steps_left,
  input  logic [STEP_W-1:0]        in_steps_right,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     out_acted,
  output logic                     out_start_motion,
  output logic                     out_node_found,
  output logic [MASK_W-1:0]        out_direction_mask,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data
);

  // readings are taken modulo 2^LEVEL_BITS, never wider than the port
  localparam int LW = (LEVEL_BITS < FIELD_LEVEL_W) ? LEVEL_BITS : FIELD_LEVEL_W;

  logic [LW-1:0]     white_r, black_r, crossing_r;
  logic [STEP_W-1:0] center_r;

  logic    s_valid_r, s_valid_nxt;
  sample_t s_sample_r;
  logic    out_valid_r, out_valid_nxt;
  result_t out_res_r;
  result_t res;
  logic    adv, take, in_acc;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      white_r    <= LW'(WHITE_LEVEL_RST);
      black_r    <= LW'(BLACK_LEVEL_RST);
      crossing_r <= LW'(CROSSING_LEVEL_RST);
      center_r   <= STEP_W'(CENTER_DISTANCE_RST);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_WHITE_LEVEL:     white_r    <= cfg_data[LW-1:0];
        CFG_BLACK_LEVEL:     black_r    <= cfg_data[LW-1:0];
        CFG_CROSSING_LEVEL:  crossing_r <= cfg_data[LW-1:0];
        CFG_CENTER_DISTANCE: center_r   <= cfg_data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // output register frees when empty or being taken
  assign adv      = !out_valid_r || !out_stall;
  assign take     = s_valid_r && adv;
  assign in_stall = s_valid_r && !adv;
  assign in_acc   = in_valid && !in_stall;

  assign s_valid_nxt   = in_acc ? 1'b1 : (take ? 1'b0 : s_valid_r);
  assign out_valid_nxt = adv ? take : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s_valid_r   <= s_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s_sample_r <= '{abort:          in_abort,
                      moving_forward: in_moving_forward,
                      left_level:     in_left_level,
                      middle_level:   in_middle_level,
                      right_level:    in_right_level,
                      steps_left:     in_steps_left,
                      steps_right:    in_steps_right};
    end
    if (take) begin
      out_res_r <= res;
    end
  end

  lnd_core #(
    .LW (LW)
  ) u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .take            (take),
    .sample          (s_sample_r),
    .white_level     (white_r),
    .black_level     (black_r),
    .crossing_level  (crossing_r),
    .center_distance (center_r),
    .res             (res)
  );

  assign out_valid          = out_valid_r;
  assign out_acted          = out_res_r.acted;
  assign out_start_motion   = out_res_r.start_motion;
  assign out_node_found     = out_res_r.node_found;
  assign out_direction_mask = out_res_r.direction_mask;

endmodule

// ----- rtl/core/lnd_core.sv -----
// Detection state (active flag, side sums, sample counter) and per-sample decision.
module lnd_core import lnd_pkg::*; #(
  parameter int LW = LEVEL_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              take,
  input  sample_t           sample,
  input  logic [LW-1:0]     white_level,
  input  logic [LW-1:0]     black_level,
  input  logic [LW-1:0]     crossing_level,
  input  logic [STEP_W-1:0] center_distance,
  output result_t           res
);

  localparam int SUM_W = LW + STEP_W;
  localparam logic [STEP_W-1:0] COUNT_MAX = {STEP_W{1'b1}};

  logic              active_r, active_nxt;
  logic [SUM_W-1:0]  left_sum_r, left_sum_nxt;
  logic [SUM_W-1:0]  right_sum_r, right_sum_nxt;
  logic [STEP_W-1:0] count_r, count_nxt;

  logic [LW-1:0]     lv, mv, rv;
  logic [SUM_W-1:0]  limit;
  logic              white, at_center;

  assign lv = sample.left_level[LW-1:0];
  assign mv = sample.middle_level[LW-1:0];
  assign rv = sample.right_level[LW-1:0];

  assign white     = mv > white_level;
  assign at_center = (sample.steps_left >= center_distance) &&
                     (sample.steps_right >= center_distance);
  // threshold times count, compared against each side sum
  assign limit     = SUM_W'(crossing_level) * SUM_W'(count_r);

  always_comb begin
    active_nxt    = active_r;
    left_sum_nxt  = left_sum_r;
    right_sum_nxt = right_sum_r;
    count_nxt     = count_r;
    res           = '0;
    if (sample.abort) begin
      active_nxt = 1'b0;
    end else if (sample.moving_forward) begin
      if (!active_r) begin
        if (white) begin
          left_sum_nxt     = '0;
          right_sum_nxt    = '0;
          count_nxt        = '0;
          active_nxt       = 1'b1;
          res.start_motion = 1'b1;
          res.acted        = 1'b1;
        end
      end else if (at_center) begin
        res.direction_mask[DIR_DOWN_BIT]  = 1'b1;
        res.direction_mask[DIR_UP_BIT]    = (lv < black_level) || (mv < black_level) ||
                                            (rv < black_level);
        res.direction_mask[DIR_LEFT_BIT]  = left_sum_r < limit;
        res.direction_mask[DIR_RIGHT_BIT] = right_sum_r < limit;
        res.node_found = 1'b1;
        res.acted      = 1'b1;
        active_nxt     = 1'b0;
      end else if (white) begin
        // counter saturates; sums freeze with it
        if (count_r != COUNT_MAX) begin
          left_sum_nxt  = left_sum_r + SUM_W'(lv);
          right_sum_nxt = right_sum_r + SUM_W'(rv);
          count_nxt     = count_r + STEP_W'(1);
        end
        res.acted = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      left_sum_r  <= '0;
      right_sum_r <= '0;
      count_r     <= '0;
    end else if (take) begin
      active_r    <= active_nxt;
      left_sum_r  <= left_sum_nxt;
      right_sum_r <= right_sum_nxt;
      count_r     <= count_nxt;
    end
  end

  a_found_ends: assert property (@(posedge clk) disable iff (!rst_n)
    take && res.node_found |=> !active_r)
    else $error("node found but detection still active");

  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    take && res.start_motion |=> active_r && count_r == '0 && left_sum_r == '0)
    else $error("detection start did not clear state");

  a_count_mono: assert property (@(posedge clk) disable iff (!rst_n)
    take && !res.start_motion |=> count_r >= $past(count_r))
    else $error("sample counter decreased without a start");

  a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !take |=> $stable(count_r) && $stable(active_r))
    else $error("state changed without a transaction");

endmodule
